@@ sv/i2cbw_pkg.sv @@
// Package: types, codes and constants shared by the I2C EEPROM byte write master.
package i2cbw_pkg;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_TICK  = 2'd0;
    localparam t_cmd CMD_WRITE = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;

    localparam logic [7:0] CTRL_BYTE     = 8'hA0;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [2:0] LAST_BYTE_IDX = 3'd3;

    localparam logic [1:0] IDX_CTRL     = 2'd0;
    localparam logic [1:0] IDX_ADDR_HI  = 2'd1;
    localparam logic [1:0] IDX_ADDR_LO  = 2'd2;
    localparam logic [1:0] IDX_DATA     = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_A     = 5'd1,
        PH_ST_B     = 5'd2,
        PH_ST_C     = 5'd3,
        PH_TX_LOW   = 5'd4,
        PH_TX_HIGH  = 5'd5,
        PH_TX_END   = 5'd6,
        PH_ACK_HIGH = 5'd7,
        PH_ACK_LOW  = 5'd8,
        PH_SP_A     = 5'd9,
        PH_SP_B     = 5'd10,
        PH_SP_C     = 5'd11,
        PH_SP_D     = 5'd12,
        PH_RX_HIGH  = 5'd13,
        PH_RX_LOW   = 5'd14
    } t_phase;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic       nack_error;
        logic [7:0] read_byte;
    } t_out_item;

endpackage

@@ sv/i2cbw_if.sv @@
// Interfaces: tick channel into the master and pin-result channel out of it.
interface i2cbw_in_if;
    import i2cbw_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface i2cbw_out_if;
    import i2cbw_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/i2c_eeprom_byte_write_master_top.sv @@
// Top level: bit-level I2C master for EEPROM byte write and byte receive.
//
// Each transfer on i_in is one bus tick: a command, a 16-bit word address,
// a data byte and the sampled SDA level. Each tick gives exactly one transfer
// on o_out with the pin levels (SCL, SDA, SDA drive enable) after that tick,
// plus busy, done, NACK error and the last received byte.
// A write command sends start, 0xA0, address high, address low and data,
// each followed by an ACK sample, then a stop; a NACK ends it without stop.
// A receive command clocks in eight bits with SDA released.
// Pipeline: input register, one pass of phase logic, result register.
// A tick passes through the input register and then the result register before
// its result is valid on o_out; one tick is taken every cycle, limited only by
// the result register draining.
// When o_out stalls the result register holds and the input register fills;
// i_in.ready drops once both are occupied and rises as soon as one drains.
// Synchronous active-low reset empties both registers and returns the bus
// state to idle with SCL and SDA low and all flags clear.
module i2c_eeprom_byte_write_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cbw_in_if.sink    i_in,
    i2cbw_out_if.source o_out
);
    import i2cbw_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_bit_count, n_bit_count;
    logic [2:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_held_address, n_held_address;
    logic [7:0]  r_held_data, n_held_data;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic        r_error, n_error;
    logic [7:0]  r_received, n_received;
    logic        n_done;

    t_phase      w_phase;
    logic [3:0]  w_bit_count;
    logic [7:0]  w_shift;
    logic [15:0] w_held_address;
    logic [7:0]  w_held_data;
    logic [3:0]  w_bit_inc;
    logic        w_adv;
    logic        w_fire;
    t_out_item   w_result;

    assign w_adv       = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_in.ready  = !r_in_valid || w_adv;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // Start a transaction from idle; its first phase runs on the same tick.
    always_comb begin
        w_phase        = r_phase;
        w_bit_count    = r_bit_count;
        w_shift        = r_shift;
        w_held_address = r_held_address;
        w_held_data    = r_held_data;
        if (r_phase == PH_IDLE) begin
            case (r_in.cmd)
                CMD_WRITE: begin
                    w_held_address = r_in.mem_address;
                    w_held_data    = r_in.write_data;
                    w_bit_count    = '0;
                    w_shift        = CTRL_BYTE;
                    w_phase        = PH_ST_A;
                end
                CMD_READ: begin
                    w_bit_count = '0;
                    w_shift     = '0;
                    w_phase     = PH_RX_HIGH;
                end
                default: ;
            endcase
        end
    end

    assign w_bit_inc = w_bit_count + 4'd1;

    // Next phase.
    always_comb begin
        unique case (w_phase)
            PH_IDLE:     n_phase = PH_IDLE;
            PH_ST_A:     n_phase = PH_ST_B;
            PH_ST_B:     n_phase = PH_ST_C;
            PH_ST_C:     n_phase = PH_TX_LOW;
            PH_TX_LOW:   n_phase = PH_TX_HIGH;
            PH_TX_HIGH:  n_phase = (w_bit_inc >= BITS_PER_BYTE) ? PH_TX_END : PH_TX_LOW;
            PH_TX_END:   n_phase = PH_ACK_HIGH;
            PH_ACK_HIGH: n_phase = PH_ACK_LOW;
            PH_ACK_LOW: begin
                if (w_shift[0]) begin
                    n_phase = PH_IDLE;
                end else if (r_byte_index < LAST_BYTE_IDX) begin
                    n_phase = PH_TX_LOW;
                end else begin
                    n_phase = PH_SP_A;
                end
            end
            PH_SP_A:     n_phase = PH_SP_B;
            PH_SP_B:     n_phase = PH_SP_C;
            PH_SP_C:     n_phase = PH_SP_D;
            PH_SP_D:     n_phase = PH_IDLE;
            PH_RX_HIGH:  n_phase = PH_RX_LOW;
            PH_RX_LOW:   n_phase = (w_bit_count >= BITS_PER_BYTE) ? PH_IDLE : PH_RX_HIGH;
            default:     n_phase = PH_IDLE;
        endcase
    end

    // Pin levels, shifter, counters and flags for this phase.
    always_comb begin
        n_bit_count    = w_bit_count;
        n_byte_index   = r_byte_index;
        n_shift        = w_shift;
        n_held_address = w_held_address;
        n_held_data    = w_held_data;
        n_scl          = r_scl;
        n_sda          = r_sda;
        n_error        = r_error;
        n_received     = r_received;
        n_done         = 1'b0;
        if (r_phase == PH_IDLE && r_in.cmd == CMD_WRITE) begin
            n_byte_index = '0;
        end
        unique case (w_phase)
            PH_ST_A: begin
                n_sda = 1'b1;
                n_scl = 1'b1;
            end
            PH_ST_B: n_sda = 1'b0;
            PH_ST_C: n_scl = 1'b0;
            PH_TX_LOW: begin
                n_scl = 1'b0;
                n_sda = w_shift[7];
            end
            PH_TX_HIGH: begin
                n_scl       = 1'b1;
                n_shift     = {w_shift[6:0], 1'b0};
                n_bit_count = w_bit_inc;
            end
            PH_TX_END: begin
                n_scl = 1'b0;
                n_sda = 1'b0;
            end
            PH_ACK_HIGH: begin
                n_scl   = 1'b1;
                n_shift = {7'd0, r_in.sda_in};
            end
            PH_ACK_LOW: begin
                n_scl = 1'b0;
                if (w_shift[0]) begin
                    n_error = 1'b1;
                    n_done  = 1'b1;
                end else if (r_byte_index < LAST_BYTE_IDX) begin
                    n_byte_index = r_byte_index + 3'd1;
                    n_bit_count  = '0;
                    // Load the next byte of the frame.
                    case (n_byte_index[1:0])
                        IDX_CTRL:    n_shift = CTRL_BYTE;
                        IDX_ADDR_HI: n_shift = w_held_address[15:8];
                        IDX_ADDR_LO: n_shift = w_held_address[7:0];
                        IDX_DATA:    n_shift = w_held_data;
                        default:     n_shift = w_held_data;
                    endcase
                end
            end
            PH_SP_A: begin
                n_sda = 1'b0;
                n_scl = 1'b0;
            end
            PH_SP_B: n_scl = 1'b1;
            PH_SP_C: n_sda = 1'b1;
            PH_SP_D: begin
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_error = 1'b0;
                n_done  = 1'b1;
            end
            PH_RX_HIGH: begin
                n_scl       = 1'b1;
                n_shift     = {w_shift[6:0], r_in.sda_in};
                n_bit_count = w_bit_inc;
            end
            PH_RX_LOW: begin
                n_scl = 1'b0;
                if (w_bit_count >= BITS_PER_BYTE) begin
                    n_received = w_shift;
                    n_done     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_result.scl_out    = n_scl;
        w_result.sda_out    = n_sda;
        w_result.sda_drive  = !(n_phase inside {PH_ACK_LOW, PH_RX_HIGH, PH_RX_LOW});
        w_result.busy_res   = (n_phase != PH_IDLE);
        w_result.done_res   = n_done;
        w_result.nack_error = n_error;
        w_result.read_byte  = n_received;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_IDLE;
            r_bit_count    <= '0;
            r_byte_index   <= '0;
            r_shift        <= '0;
            r_held_address <= '0;
            r_held_data    <= '0;
            r_scl          <= 1'b0;
            r_sda          <= 1'b0;
            r_error        <= 1'b0;
            r_received     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_phase        <= n_phase;
                r_bit_count    <= n_bit_count;
                r_byte_index   <= n_byte_index;
                r_shift        <= n_shift;
                r_held_address <= n_held_address;
                r_held_data    <= n_held_data;
                r_scl          <= n_scl;
                r_sda          <= n_sda;
                r_error        <= n_error;
                r_received     <= n_received;
            end
        end
    end

    // Payload registers: load only, no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.payload;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

endmodule

@@ sv/i2cbw_checker.sv @@
// Checker: port-level assertions on the I2C EEPROM byte write master, with bind.
module i2cbw_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input i2cbw_pkg::t_out_item i_out_payload
);
    import i2cbw_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled result changed or dropped");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A finishing tick leaves the bus idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.done_res |-> !i_out_payload.busy_res)
        else $error("done reported while still busy");

    // SDA is released only inside a transaction.
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_payload.sda_drive |-> i_out_payload.busy_res)
        else $error("SDA released while idle");

    // With the result side free, the block keeps taking ticks.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !i_in_ready |-> 1'b0)
        else $error("input stalled with empty result register");

endmodule

bind i2c_eeprom_byte_write_master_top i2cbw_checker u_i2cbw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

@@ sim/i2cbw_bus_checker.sv @@
// Bus checker: predicts the pin result of every accepted tick and compares it on o_out.
module i2cbw_bus_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    i2cbw_in_if   i_tick,
    i2cbw_out_if  i_pins,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbw_pkg::*;

    t_phase      bus_phase;
    logic [3:0]  bits_done;
    logic [2:0]  byte_sel;
    logic [7:0]  shifter;
    logic [15:0] addr_hold;
    logic [7:0]  data_hold;
    logic        scl_lvl;
    logic        sda_lvl;
    logic        nack_flag;
    logic [7:0]  rx_byte;

    t_out_item   expected_pins[$];

    // Advance the bus state by one tick and return the pin levels after it.
    function automatic t_out_item step_bus(input t_in_item it);
        t_out_item pins;
        logic      fin;
        fin = 1'b0;
        if (bus_phase == PH_IDLE) begin
            if (it.cmd == CMD_WRITE) begin
                addr_hold = it.mem_address;
                data_hold = it.write_data;
                byte_sel  = '0;
                bits_done = '0;
                shifter   = CTRL_BYTE;
                bus_phase = PH_ST_A;
            end else if (it.cmd == CMD_READ) begin
                bits_done = '0;
                shifter   = '0;
                bus_phase = PH_RX_HIGH;
            end
        end
        case (bus_phase)
            PH_IDLE: ;
            PH_ST_A: begin
                sda_lvl   = 1'b1;
                scl_lvl   = 1'b1;
                bus_phase = PH_ST_B;
            end
            PH_ST_B: begin
                sda_lvl   = 1'b0;
                bus_phase = PH_ST_C;
            end
            PH_ST_C: begin
                scl_lvl   = 1'b0;
                bus_phase = PH_TX_LOW;
            end
            PH_TX_LOW: begin
                scl_lvl   = 1'b0;
                sda_lvl   = shifter[7];
                bus_phase = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                scl_lvl   = 1'b1;
                shifter   = shifter << 1;
                bits_done = bits_done + 4'd1;
                bus_phase = (bits_done >= BITS_PER_BYTE) ? PH_TX_END : PH_TX_LOW;
            end
            PH_TX_END: begin
                scl_lvl   = 1'b0;
                sda_lvl   = 1'b0;
                bus_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                scl_lvl   = 1'b1;
                shifter   = {7'd0, it.sda_in};
                bus_phase = PH_ACK_LOW;
            end
            PH_ACK_LOW: begin
                scl_lvl = 1'b0;
                if (shifter[0]) begin
                    // NACK: abandon without a stop condition
                    nack_flag = 1'b1;
                    fin       = 1'b1;
                    bus_phase = PH_IDLE;
                end else if (byte_sel < LAST_BYTE_IDX) begin
                    byte_sel = byte_sel + 3'd1;
                    case (byte_sel[1:0])
                        IDX_CTRL:    shifter = CTRL_BYTE;
                        IDX_ADDR_HI: shifter = addr_hold[15:8];
                        IDX_ADDR_LO: shifter = addr_hold[7:0];
                        default:     shifter = data_hold;
                    endcase
                    bits_done = '0;
                    bus_phase = PH_TX_LOW;
                end else begin
                    bus_phase = PH_SP_A;
                end
            end
            PH_SP_A: begin
                sda_lvl   = 1'b0;
                scl_lvl   = 1'b0;
                bus_phase = PH_SP_B;
            end
            PH_SP_B: begin
                scl_lvl   = 1'b1;
                bus_phase = PH_SP_C;
            end
            PH_SP_C: begin
                sda_lvl   = 1'b1;
                bus_phase = PH_SP_D;
            end
            PH_SP_D: begin
                scl_lvl   = 1'b0;
                sda_lvl   = 1'b0;
                nack_flag = 1'b0;
                fin       = 1'b1;
                bus_phase = PH_IDLE;
            end
            PH_RX_HIGH: begin
                scl_lvl   = 1'b1;
                shifter   = {shifter[6:0], it.sda_in};
                bits_done = bits_done + 4'd1;
                bus_phase = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                scl_lvl = 1'b0;
                if (bits_done >= BITS_PER_BYTE) begin
                    rx_byte   = shifter;
                    fin       = 1'b1;
                    bus_phase = PH_IDLE;
                end else begin
                    bus_phase = PH_RX_HIGH;
                end
            end
            default: bus_phase = PH_IDLE;
        endcase
        pins.scl_out    = scl_lvl;
        pins.sda_out    = sda_lvl;
        pins.sda_drive  = !(bus_phase inside {PH_ACK_LOW, PH_RX_HIGH, PH_RX_LOW});
        pins.busy_res   = (bus_phase != PH_IDLE);
        pins.done_res   = fin;
        pins.nack_error = nack_flag;
        pins.read_byte  = rx_byte;
        return pins;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            bus_phase    = PH_IDLE;
            bits_done    = '0;
            byte_sel     = '0;
            shifter      = '0;
            addr_hold    = '0;
            data_hold    = '0;
            scl_lvl      = 1'b0;
            sda_lvl      = 1'b0;
            nack_flag    = 1'b0;
            rx_byte      = '0;
            o_fail_count = 0;
            expected_pins.delete();
        end else begin
            if (i_tick.valid && i_tick.ready)
                expected_pins.push_back(step_bus(i_tick.payload));
            if (i_pins.valid && i_pins.ready) begin
                got = i_pins.payload;
                if (expected_pins.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: pin result with nothing expected, actual %p", $time, got);
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl_out",    8'(want.scl_out),    8'(got.scl_out));
                    check_field("sda_out",    8'(want.sda_out),    8'(got.sda_out));
                    check_field("sda_drive",  8'(want.sda_drive),  8'(got.sda_drive));
                    check_field("busy_res",   8'(want.busy_res),   8'(got.busy_res));
                    check_field("done_res",   8'(want.done_res),   8'(got.done_res));
                    check_field("nack_error", 8'(want.nack_error), 8'(got.nack_error));
                    check_field("read_byte",  want.read_byte,      got.read_byte);
                end
            end
        end
        o_pending = expected_pins.size();
    end

endmodule

@@ sim/i2c_eeprom_byte_write_master_top_test.sv @@
// Testbench top: drives bus ticks and receiver stalls into the I2C master and gives the verdict.
module i2c_eeprom_byte_write_master_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbw_pkg::*;

    localparam t_cmd CMD_UNUSED   = 2'd3;
    localparam int   START_TICKS  = 3;
    localparam int   BYTE_TICKS   = 19;
    localparam int   ACK_SLOT     = 17;
    localparam int   WRITE_TICKS  = START_TICKS + 4 * BYTE_TICKS + 4;
    localparam int   READ_TICKS   = 16;
    localparam int   RANDOM_TICKS = 640;
    localparam int   NO_NACK      = -1;

    logic i_clk;
    logic i_rst_n;
    int   check_fails;
    int   check_pending;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   txn_ticks;
    int   src_plan[4]  = '{0, 54, 0, 25};
    int   sink_plan[4] = '{0, 0, 54, 25};

    i2cbw_in_if  tick_ch ();
    i2cbw_out_if pins_ch ();

    i2c_eeprom_byte_write_master_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch),
        .o_out   (pins_ch)
    );

    i2cbw_bus_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_pins       (pins_ch),
        .o_fail_count (check_fails),
        .o_pending    (check_pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        pins_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Hold one tick on i_in until it is transferred; valid stays high afterwards.
    task automatic send_tick(input t_in_item tk);
        while ($urandom_range(99) < src_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.payload <= tk;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
    endtask

    // Mostly plain ticks, now and then a command that a busy master must drop.
    function automatic t_cmd busy_cmd();
        return ($urandom_range(7) == 0) ? t_cmd'($urandom_range(3)) : CMD_TICK;
    endfunction

    task automatic run_write(input logic [15:0] addr, input logic [7:0] data,
                             input int nack_at);
        t_in_item tk;
        int       len;
        int       slot;
        len = (nack_at < 0) ? WRITE_TICKS : START_TICKS + BYTE_TICKS * (nack_at + 1);
        for (int k = 0; k < len; k++) begin
            slot           = (k - START_TICKS) % BYTE_TICKS;
            tk.cmd         = (k == 0) ? CMD_WRITE : busy_cmd();
            tk.mem_address = (k == 0) ? addr : 16'($urandom);
            tk.write_data  = (k == 0) ? data : 8'($urandom);
            if (k >= START_TICKS && k < START_TICKS + 4 * BYTE_TICKS && slot == ACK_SLOT)
                tk.sda_in = ((k - START_TICKS) / BYTE_TICKS == nack_at);
            else
                tk.sda_in = 1'($urandom);
            send_tick(tk);
        end
        txn_ticks += len;
    endtask

    task automatic run_read(input logic [7:0] pattern);
        t_in_item tk;
        for (int k = 0; k < READ_TICKS; k++) begin
            tk.cmd         = (k == 0) ? CMD_READ : busy_cmd();
            tk.mem_address = 16'($urandom);
            tk.write_data  = 8'($urandom);
            // even ticks sample SDA with SCL high
            tk.sda_in      = (k % 2 == 0) ? pattern[7 - k / 2] : 1'($urandom);
            send_tick(tk);
        end
        txn_ticks += READ_TICKS;
    endtask

    task automatic run_idle(input int n);
        t_in_item tk;
        for (int k = 0; k < n; k++) begin
            tk.cmd         = $urandom_range(1) ? CMD_UNUSED : CMD_TICK;
            tk.mem_address = 16'($urandom);
            tk.write_data  = 8'($urandom);
            tk.sda_in      = 1'($urandom);
            send_tick(tk);
        end
    endtask

    initial begin
        int phase_end;
        tick_ch.valid   <= 1'b0;
        tick_ch.payload <= '0;
        i_rst_n         <= 1'b0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        txn_ticks       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick('{CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1});
        send_tick('{CMD_TICK, 16'h0000, 8'h00, 1'b0});
        run_write(16'hFFFF, 8'hFF, NO_NACK);
        run_write(16'h0000, 8'h00, NO_NACK);
        run_read(8'hFF);
        run_read(8'h00);
        for (int b = 0; b < 4; b++) run_write(16'($urandom), 8'($urandom), b);
        // error flag survives a receive and clears on the next good write
        run_read(8'hA5);
        run_write(16'h8001, 8'h7E, NO_NACK);

        for (int ph = 0; ph < 4; ph++) begin
            // drain the master before changing the idling pattern
            tick_ch.valid <= 1'b0;
            do @(posedge i_clk); while (check_pending != 0);
            src_idle_pct   = src_plan[ph];
            sink_stall_pct = sink_plan[ph];
            phase_end      = txn_ticks + RANDOM_TICKS / 4;
            while (txn_ticks < phase_end) begin
                if ($urandom_range(99) < 55)
                    run_write(16'($urandom), 8'($urandom),
                              ($urandom_range(7) == 0) ? int'($urandom_range(3)) : NO_NACK);
                else
                    run_read(8'($urandom));
                run_idle($urandom_range(3));
            end
        end

        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (check_pending != 0);
        repeat (8) @(posedge i_clk);
        if (check_fails == 0)
            $display("** i2c_eeprom_byte_write_master_top: PASSED **");
        else
            $display("** i2c_eeprom_byte_write_master_top: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("%0t ns: timeout", $time);
        $display("** i2c_eeprom_byte_write_master_top: FAILED **");
        $finish;
    end

endmodule
